[rtl/trle_pkg.sv]
// Shared types, constants and the pixel formatting function of the targa
// run-length packet decoder. No dependencies; used by trle_cfg_if and the top level.
package trle_pkg;

  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_CODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_TOTAL = 1'd1;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic [1:0]  DEPTH_RESET = DEPTH_24;
  localparam logic [31:0] TOTAL_RESET = 32'd1;

  typedef logic [3:0][7:0] pix_bytes_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [2:0] bytes_valid;
    logic [7:0] repeat_res;
    logic       image_done;
    logic       overrun;
  } pix_t;

  function automatic pix_t format_pixel(input logic [1:0] depth, input pix_bytes_t pb,
                                        input logic [7:0] rep, input logic done,
                                        input logic over);
    pix_t        p;
    logic [15:0] v;
    p = '0;
    v = {pb[1], pb[0]};
    p.repeat_res = rep;
    p.image_done = done;
    p.overrun    = over;
    unique case (depth)
      DEPTH_8: begin
        p.chan0       = pb[0];
        p.bytes_valid = 3'd1;
      end
      DEPTH_16: begin
        p.chan0       = {v[4:0], 3'b000};
        p.chan1       = {v[9:5], 3'b000};
        p.chan2       = {v[14:10], 3'b000};
        p.bytes_valid = 3'd3;
      end
      DEPTH_24: begin
        p.chan0       = pb[0];
        p.chan1       = pb[1];
        p.chan2       = pb[2];
        p.bytes_valid = 3'd3;
      end
      default: begin
        p.chan0       = pb[0];
        p.chan1       = pb[1];
        p.chan2       = pb[2];
        p.chan3       = pb[3];
        p.bytes_valid = 3'd4;
      end
    endcase
    return p;
  endfunction

endpackage

[rtl/trle_byte_if.sv]
// Valid/ready channel that carries one byte of compressed pixel data.
// No dependencies.
interface trle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

[rtl/trle_pixel_if.sv]
// Valid/ready channel that carries one decoded pixel with its repeat count and flags.
// No dependencies.
interface trle_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;
  logic [2:0] bytes_valid;
  logic [7:0] repeat_res;
  logic       image_done;
  logic       overrun;

  modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                  output bytes_valid, output repeat_res, output image_done,
                  output overrun, input ready);
  modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
                input bytes_valid, input repeat_res, input image_done,
                input overrun, output ready);
endinterface

[rtl/trle_cfg_if.sv]
// Valid/ready configuration write channel with register index and write data.
// Depends on trle_pkg for the index width.
interface trle_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [trle_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/tga_rle_packet_decoder_top.sv]
// Top level of the targa run-length packet decoder.
// Depends on trle_pkg and the interfaces trle_byte_if, trle_pixel_if and trle_cfg_if.
//
// Usage:
//   stream carries the compressed pixel data, one byte per transfer. A header
//   byte opens a packet; the data bytes of a run or raw packet follow.
//   pixel gives one transfer for every finished pixel, with its repeat count,
//   an image_done flag on the last pixel of an image and an overrun flag when
//   a packet asked for more pixels than the image had left.
//   cfg writes depth_code (index 0) and pixel_total (index 1); it is always
//   ready. The user must write it only while no byte is in flight; the block
//   does not enforce this. A pixel is registered when its last byte is
//   transferred. Throughput: one byte per cycle, a header byte or a data
//   byte, while stream is ready. The byte is decoded by the logic between
//   the state registers and the pixel output register.
//   When pixel stalls, one further pixel is held in a skid register, and
//   stream drops ready only while that skid register is full.
//   Reset: depth_code returns to 24 bit, pixel_total to one, and the decoder
//   waits for the header of a new image with both output registers empty.
module tga_rle_packet_decoder_top (
  input logic           clk,
  input logic           rst,
  trle_byte_if.sink     stream,
  trle_pixel_if.source  pixel,
  trle_cfg_if.sink      cfg
);
  import trle_pkg::*;

  logic [1:0]  depth_code;
  logic [31:0] pixel_total;

  logic        expect_header, expect_header_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  packet_pixels_left, packet_pixels_left_next;
  logic [1:0]  byte_position, byte_position_next;
  pix_bytes_t  pixel_bytes, pixel_bytes_next;
  logic [31:0] image_pixels_left, image_pixels_left_next;

  pix_t        out_reg, skid_reg, result;
  logic        out_valid, skid_valid;
  logic        produce;
  logic        stream_xfer, pixel_xfer;

  assign stream.ready = !skid_valid;
  assign stream_xfer  = stream.valid && stream.ready;
  assign pixel_xfer   = out_valid && pixel.ready;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code  <= DEPTH_RESET;
      pixel_total <= TOTAL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DEPTH_CODE:  depth_code  <= cfg.data[1:0];
        CFG_PIXEL_TOTAL: pixel_total <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pix_bytes_t  pix_cur;
    logic [7:0]  count;
    logic        over;
    logic        done;
    logic [31:0] ipl_dec;
    logic [7:0]  ppl_dec;
    expect_header_next      = expect_header;
    packet_is_run_next      = packet_is_run;
    packet_pixels_left_next = packet_pixels_left;
    byte_position_next      = byte_position;
    pixel_bytes_next        = pixel_bytes;
    image_pixels_left_next  = image_pixels_left;
    produce                 = 1'b0;
    pix_cur                 = pixel_bytes;
    pix_cur[byte_position]  = stream.stream_byte;
    count                   = packet_pixels_left;
    over                    = 1'b0;
    done                    = 1'b0;
    ipl_dec = (image_pixels_left != 32'd0) ? image_pixels_left - 32'd1 : 32'd0;
    ppl_dec = (packet_pixels_left != 8'd0) ? packet_pixels_left - 8'd1 : 8'd0;
    if (stream_xfer) begin
      if (expect_header) begin
        if (image_pixels_left == 32'd0) begin
          image_pixels_left_next = (pixel_total == 32'd0) ? 32'd1 : pixel_total;
        end
        packet_is_run_next      = stream.stream_byte[7];
        packet_pixels_left_next = {1'b0, stream.stream_byte[6:0]} + 8'd1;
        byte_position_next      = 2'd0;
        expect_header_next      = 1'b0;
      end else begin
        pixel_bytes_next = pix_cur;
        if (byte_position < depth_code) begin
          byte_position_next = byte_position + 2'd1;
        end else begin
          byte_position_next = 2'd0;
          produce            = 1'b1;
          if (packet_is_run) begin
            if ({24'd0, packet_pixels_left} > image_pixels_left) begin
              count = image_pixels_left[7:0];
              over  = 1'b1;
            end
            image_pixels_left_next  = image_pixels_left - {24'd0, count};
            packet_pixels_left_next = 8'd0;
            expect_header_next      = 1'b1;
            done                    = (image_pixels_left_next == 32'd0);
          end else begin
            count                   = 8'd1;
            image_pixels_left_next  = ipl_dec;
            done                    = (ipl_dec == 32'd0);
            over                    = done && (ppl_dec != 8'd0);
            packet_pixels_left_next = over ? 8'd0 : ppl_dec;
            expect_header_next      = (packet_pixels_left_next == 8'd0);
          end
        end
      end
    end
    result = format_pixel(depth_code, pix_cur, count, done, over);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header      <= 1'b1;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= 8'd0;
      byte_position      <= 2'd0;
      pixel_bytes        <= '0;
      image_pixels_left  <= 32'd0;
    end else begin
      expect_header      <= expect_header_next;
      packet_is_run      <= packet_is_run_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_position      <= byte_position_next;
      pixel_bytes        <= pixel_bytes_next;
      image_pixels_left  <= image_pixels_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (produce) begin
        if (out_valid && !pixel.ready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (skid_valid && pixel.ready) begin
        skid_valid <= 1'b0;
      end else if (pixel_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce && out_valid && !pixel.ready) begin
      skid_reg <= result;
    end
    if (produce && (!out_valid || pixel.ready)) begin
      out_reg <= result;
    end else if (skid_valid && pixel.ready) begin
      out_reg <= skid_reg;
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.chan0       = out_reg.chan0;
  assign pixel.chan1       = out_reg.chan1;
  assign pixel.chan2       = out_reg.chan2;
  assign pixel.chan3       = out_reg.chan3;
  assign pixel.bytes_valid = out_reg.bytes_valid;
  assign pixel.repeat_res  = out_reg.repeat_res;
  assign pixel.image_done  = out_reg.image_done;
  assign pixel.overrun     = out_reg.overrun;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a pixel while the output register is empty");

  a_header_loads_image: assert property (@(posedge clk) disable iff (rst)
    (stream_xfer && expect_header) |=> (image_pixels_left != 32'd0))
    else $error("image pixel count is zero after a header");

  a_done_expects_header: assert property (@(posedge clk) disable iff (rst)
    (produce && result.image_done) |=> expect_header)
    else $error("a finished image did not return to header state");

  a_repeat_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reg.repeat_res != 8'd0))
    else $error("pixel given with a zero repeat count");
`endif

endmodule

[tb/trle_pixel_checker.sv]
// Passive checker for the targa run-length packet decoder: watches the byte,
// pixel and configuration channels, predicts every pixel and compares it.
// Depends on trle_pkg for the pixel type, depth codes and register indexes.
module trle_pixel_checker
  import trle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  input  logic                   byte_ready,
  input  logic [7:0]             byte_data,
  input  logic                   pix_valid,
  input  logic                   pix_ready,
  input  logic [7:0]             pix_chan0,
  input  logic [7:0]             pix_chan1,
  input  logic [7:0]             pix_chan2,
  input  logic [7:0]             pix_chan3,
  input  logic [2:0]             pix_bytes_valid,
  input  logic [7:0]             pix_repeat_res,
  input  logic                   pix_image_done,
  input  logic                   pix_overrun,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0]  depth_r;
  logic [31:0] total_r;
  logic        hdr_wait;
  logic        pkt_run;
  logic [7:0]  pkt_left;
  logic [1:0]  bpos;
  logic [7:0]  pbytes [4];
  logic [31:0] img_left;

  pix_t expected_pixels [$];
  pix_t seen;
  pix_t want;
  int   mismatches = 0;
  int   pixel_index = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    mismatches++;
    if (mismatches <= 200) begin
      $display("mismatch on pixel %0d, %s: got %0h, expected %0h", pixel_index, what, got,
               wanted);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    pix_t        p;
    logic [31:0] run_count;
    logic [15:0] word;
    logic        over;
    logic        done;
    if (hdr_wait) begin
      if (img_left == 0) img_left = (total_r == 0) ? 32'd1 : total_r;
      pkt_run  = b[7];
      pkt_left = {1'b0, b[6:0]} + 8'd1;
      bpos     = 2'd0;
      hdr_wait = 1'b0;
    end else begin
      pbytes[bpos] = b;
      if ({1'b0, bpos} + 3'd1 < {1'b0, depth_r} + 3'd1) begin
        bpos = bpos + 2'd1;
      end else begin
        bpos = 2'd0;
        p    = '0;
        if (pkt_run) begin
          run_count = {24'd0, pkt_left};
          over      = 1'b0;
          if (run_count > img_left) begin
            run_count = img_left;
            over      = 1'b1;
          end
          img_left     = img_left - run_count;
          pkt_left     = 8'd0;
          hdr_wait     = 1'b1;
          p.repeat_res = run_count[7:0];
        end else begin
          if (img_left > 0) img_left = img_left - 32'd1;
          if (pkt_left > 0) pkt_left = pkt_left - 8'd1;
          over = 1'b0;
          if (img_left == 0 && pkt_left > 0) begin
            over     = 1'b1;
            pkt_left = 8'd0;
          end
          if (pkt_left == 0) hdr_wait = 1'b1;
          p.repeat_res = 8'd1;
        end
        done         = (img_left == 0);
        p.image_done = done;
        p.overrun    = over;
        case (depth_r)
          DEPTH_8: begin
            p.chan0       = pbytes[0];
            p.bytes_valid = 3'd1;
          end
          DEPTH_16: begin
            word          = {pbytes[1], pbytes[0]};
            p.chan0       = 8'((word & 16'h001F) << 3);
            p.chan1       = 8'(((word >> 5) & 16'h001F) << 3);
            p.chan2       = 8'(((word >> 10) & 16'h001F) << 3);
            p.bytes_valid = 3'd3;
          end
          DEPTH_24: begin
            p.chan0       = pbytes[0];
            p.chan1       = pbytes[1];
            p.chan2       = pbytes[2];
            p.bytes_valid = 3'd3;
          end
          default: begin
            p.chan0       = pbytes[0];
            p.chan1       = pbytes[1];
            p.chan2       = pbytes[2];
            p.chan3       = pbytes[3];
            p.bytes_valid = 3'd4;
          end
        endcase
        expected_pixels.push_back(p);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      depth_r  = DEPTH_RESET;
      total_r  = TOTAL_RESET;
      hdr_wait = 1'b1;
      pkt_run  = 1'b0;
      pkt_left = 8'd0;
      bpos     = 2'd0;
      img_left = 32'd0;
      foreach (pbytes[i]) pbytes[i] = 8'd0;
      expected_pixels.delete();
    end else begin
      if (pix_valid && pix_ready) begin
        seen.chan0       = pix_chan0;
        seen.chan1       = pix_chan1;
        seen.chan2       = pix_chan2;
        seen.chan3       = pix_chan3;
        seen.bytes_valid = pix_bytes_valid;
        seen.repeat_res  = pix_repeat_res;
        seen.image_done  = pix_image_done;
        seen.overrun     = pix_overrun;
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel transfer with none expected", 32'd0, 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (seen.chan0 != want.chan0) begin
            report_mismatch("chan0", 32'(seen.chan0), 32'(want.chan0));
          end
          if (seen.chan1 != want.chan1) begin
            report_mismatch("chan1", 32'(seen.chan1), 32'(want.chan1));
          end
          if (seen.chan2 != want.chan2) begin
            report_mismatch("chan2", 32'(seen.chan2), 32'(want.chan2));
          end
          if (seen.chan3 != want.chan3) begin
            report_mismatch("chan3", 32'(seen.chan3), 32'(want.chan3));
          end
          if (seen.bytes_valid != want.bytes_valid) begin
            report_mismatch("bytes_valid", 32'(seen.bytes_valid), 32'(want.bytes_valid));
          end
          if (seen.repeat_res != want.repeat_res) begin
            report_mismatch("repeat_res", 32'(seen.repeat_res), 32'(want.repeat_res));
          end
          if (seen.image_done != want.image_done) begin
            report_mismatch("image_done", 32'(seen.image_done), 32'(want.image_done));
          end
          if (seen.overrun != want.overrun) begin
            report_mismatch("overrun", 32'(seen.overrun), 32'(want.overrun));
          end
        end
        pixel_index++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEPTH_CODE:  depth_r = cfg_data[1:0];
          CFG_PIXEL_TOTAL: total_r = cfg_data;
          default: ;
        endcase
      end
      if (byte_valid && byte_ready) decode_byte(byte_data);
    end
    pending <= expected_pixels.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the decoder testbench: clock, reset, byte stimulus, pixel back-pressure,
// configuration phases and the verdict. Depends on trle_pkg, the channel
// interfaces, tga_rle_packet_decoder_top and trle_pixel_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1725;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trle_byte_if  stream ();
  trle_pixel_if pixel ();
  trle_cfg_if   cfg ();

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          random_sent;
  int          sel;
  logic [1:0]  depth_sel;
  logic [31:0] total_sel;
  bit          src_idle;
  bit          snk_idle;
  logic [7:0]  byte_plan [$];

  tga_rle_packet_decoder_top uut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .pixel  (pixel),
    .cfg    (cfg)
  );

  trle_pixel_checker chk (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (stream.valid),
    .byte_ready      (stream.ready),
    .byte_data       (stream.stream_byte),
    .pix_valid       (pixel.valid),
    .pix_ready       (pixel.ready),
    .pix_chan0       (pixel.chan0),
    .pix_chan1       (pixel.chan1),
    .pix_chan2       (pixel.chan2),
    .pix_chan3       (pixel.chan3),
    .pix_bytes_valid (pixel.bytes_valid),
    .pix_repeat_res  (pixel.repeat_res),
    .pix_image_done  (pixel.image_done),
    .pix_overrun     (pixel.overrun),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL tga_rle_packet_decoder_top");
      $finish;
    end
  end

  initial begin
    int gap;
    pixel.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = snk_idle ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        pixel.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pixel.ready <= 1'b1;
      do @(posedge clk); while (!pixel.valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      stream.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream.valid       <= 1'b1;
    stream.stream_byte <= b;
    do @(posedge clk); while (!stream.ready);
  endtask

  task automatic write_config(input logic [1:0] depth, input logic [31:0] total);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_DEPTH_CODE;
    cfg.data  <= {30'd0, depth};
    do @(posedge clk); while (!cfg.ready);
    cfg.index <= CFG_PIXEL_TOTAL;
    cfg.data  <= total;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Sends the planned bytes, then waits until every predicted pixel has arrived.
  task automatic run_phase();
    foreach (byte_plan[i]) send_byte(byte_plan[i]);
    stream.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Plans mostly well-formed images with random pixels, plus some packets that
  // overrun the image and an occasional cut into the bytes of the last pixel.
  task automatic build_phase(input logic [1:0] depth, input logic [31:0] total);
    int unsigned room;
    int unsigned eff;
    int unsigned count;
    int unsigned npix;
    int          images;
    int          bpp;
    int          r;
    logic        is_run;
    logic [6:0]  len_m1;
    eff    = (total == 0) ? 1 : total;
    room   = eff;
    bpp    = int'(depth) + 1;
    images = 0;
    byte_plan.delete();
    while (images < 3 && byte_plan.size() < 200) begin
      r = $urandom_range(0, 9);
      if (r == 0) count = 128;
      else if (r == 1) count = (room < 124) ? room + $urandom_range(1, 4) : 128;
      else count = $urandom_range(1, (room < 16) ? room : 16);
      is_run = 1'($urandom_range(0, 1));
      len_m1 = 7'(count - 1);
      byte_plan.push_back({is_run, len_m1});
      npix = is_run ? 1 : ((count > room) ? room : count);
      repeat (npix * bpp) byte_plan.push_back(8'($urandom_range(0, 255)));
      room = (count > room) ? 0 : room - count;
      if (room == 0) begin
        room = eff;
        images++;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, bpp)) void'(byte_plan.pop_back());
    end
  endtask

  initial begin
    stream.valid       <= 1'b0;
    stream.stream_byte <= 8'h00;
    cfg.valid          <= 1'b0;
    cfg.index          <= CFG_DEPTH_CODE;
    cfg.data           <= 32'd0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    byte_plan = '{8'h00, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    run_phase();
    write_config(DEPTH_8, 32'd3);
    byte_plan = '{8'h85, 8'hAA, 8'h04, 8'h00, 8'hFF, 8'h7F};
    run_phase();
    write_config(DEPTH_16, 32'd0);
    byte_plan = '{8'h80, 8'hFF, 8'hFF};
    run_phase();
    write_config(DEPTH_32, 32'd2);
    byte_plan = '{8'h81, 8'h01, 8'h02, 8'h04, 8'h08, 8'h00, 8'h10, 8'h20};
    run_phase();
    write_config(DEPTH_8, 32'd5);
    byte_plan = '{8'h40, 8'h00, 8'h3C};
    run_phase();

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      depth_sel = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 19);
      if (sel < 12) total_sel = $urandom_range(1, 12);
      else if (sel < 16) total_sel = $urandom_range(13, 300);
      else if (sel == 16) total_sel = 32'd0;
      else if (sel == 17) total_sel = 32'd1;
      else if (sel == 18) total_sel = 32'd4294836225;
      else total_sel = 32'hFFFF_FFFF;
      write_config(depth_sel, total_sel);
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      build_phase(depth_sel, total_sel);
      random_sent += byte_plan.size();
      run_phase();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS tga_rle_packet_decoder_top");
    end else begin
      $display("FAIL tga_rle_packet_decoder_top");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/trle_pkg.sv
rtl/trle_byte_if.sv
rtl/trle_pixel_if.sv
rtl/trle_cfg_if.sv
rtl/tga_rle_packet_decoder_top.sv
tb/trle_pixel_checker.sv
tb/tb_top.sv
